### rtl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants for the cooldown timer table.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int TIME_W       = 20;
  localparam int STEP_W       = 16;
  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 8;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd17;

  typedef enum logic [1:0] {
    CMD_PUSH     = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_QUERY_KT = 2'd2,
    CMD_QUERY_K  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EV_STARTED  = 2'd0,
    EV_EXPIRED  = 2'd1,
    EV_QUERY    = 2'd2,
    EV_REJECTED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEL_PUSH = 2'd0,
    SEL_HIT  = 2'd1,
    SEL_MISS = 2'd2,
    SEL_HELD = 2'd3
  } sel_t;

  typedef struct packed {
    logic load;
    logic push_write;
    logic step;
    logic keep;
    logic hold;
    logic commit;
    logic out_load;
    sel_t out_sel;
    logic out_last;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic scan_done;
    logic hit;
    logic expired;
    logic out_free;
    logic held_valid;
  } stat_t;

endpackage

### rtl/cooldown_timer_table.sv
// ----------------------------------------------------------------------------
// cooldown_timer_table
// Ordered table of countdown timers with push, tick expiry and key queries.
// ----------------------------------------------------------------------------
// order: a push goes S_IDLE, S_DONE; a query or tick scans S_READ, S_EVAL per stored
// entry; a query hit leaves via S_HIT, a miss via S_DONE, and a tick ends in S_FLUSH
// flow: one word in flight, next taken the cycle after the last result is loaded;
// each entry costs a registered read and a compare; a full output register stalls
// reset: empties the table and sets tick_step to 17; no clearing pass
module cooldown_timer_table #(
  parameter int DEPTH    = cdt_pkg::DEPTH_DEF,
  parameter int KEY_BITS = cdt_pkg::KEY_BITS_DEF,
  parameter int IN_W     = ((KEY_BITS + 1 + cdt_pkg::TIME_W + 7) / 8) * 8,
  parameter int OUT_W    = ((KEY_BITS + 2 + cdt_pkg::TIME_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [cdt_pkg::STEP_W-1:0] cfg_wdata,   // tick_step
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [IN_W-1:0]            s_tdata,     // key, cd_type, duration
  input  logic [1:0]                 s_tuser,     // command
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_W-1:0]           m_tdata,     // key_out, type_out, remaining, found
  output logic [1:0]                 m_tuser,     // event_kind
  output logic                       m_tlast
);

  cdt_pkg::ctrl_t ctl;
  cdt_pkg::stat_t st;

  cdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_cmd   (cdt_pkg::cmd_t'(s_tuser)),
    .s_tready (s_tready),
    .st       (st),
    .ctl      (ctl)
  );

  cdt_datapath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .IN_W     (IN_W),
    .OUT_W    (OUT_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .ctl       (ctl),
    .st        (st)
  );

endmodule

### rtl/cdt_ctrl.sv
// ----------------------------------------------------------------------------
// cdt_ctrl
// Sequencer for push, tick scan with compaction, and query scan.
// ----------------------------------------------------------------------------
module cdt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  cdt_pkg::cmd_t   in_cmd,
  output logic            s_tready,
  input  cdt_pkg::stat_t  st,
  output cdt_pkg::ctrl_t  ctl
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_HIT   = 6'b001000,
    S_DONE  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    ctl          = '0;
    ctl.out_sel  = cdt_pkg::SEL_PUSH;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.load   = 1'b1;
          state_next = (in_cmd == cdt_pkg::CMD_PUSH) ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        if (st.scan_done) begin
          state_next = (st.cmd == cdt_pkg::CMD_TICK) ? S_FLUSH : S_DONE;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.cmd == cdt_pkg::CMD_TICK) begin
          if (!st.expired) begin
            ctl.keep   = 1'b1;
            ctl.step   = 1'b1;
            state_next = S_READ;
          end else if (!st.held_valid || st.out_free) begin
            ctl.out_load = st.held_valid;
            ctl.out_sel  = cdt_pkg::SEL_HELD;
            ctl.hold     = 1'b1;
            ctl.step     = 1'b1;
            state_next   = S_READ;
          end
        end else if (st.hit) begin
          state_next = S_HIT;
        end else begin
          ctl.step   = 1'b1;
          state_next = S_READ;
        end
      end
      S_HIT: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_sel  = cdt_pkg::SEL_HIT;
          ctl.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_last   = 1'b1;
          ctl.push_write = (st.cmd == cdt_pkg::CMD_PUSH);
          ctl.out_sel    = (st.cmd == cdt_pkg::CMD_PUSH) ? cdt_pkg::SEL_PUSH
                                                         : cdt_pkg::SEL_MISS;
          state_next     = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!st.held_valid || st.out_free) begin
          ctl.out_load = st.held_valid;
          ctl.out_sel  = cdt_pkg::SEL_HELD;
          ctl.out_last = 1'b1;
          ctl.commit   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/cdt_datapath.sv
// ----------------------------------------------------------------------------
// cdt_datapath
// Timer store, scan index, compaction pointer, held expiry and output word.
// ----------------------------------------------------------------------------
module cdt_datapath #(
  parameter int DEPTH    = cdt_pkg::DEPTH_DEF,
  parameter int KEY_BITS = cdt_pkg::KEY_BITS_DEF,
  parameter int IN_W     = ((KEY_BITS + 1 + cdt_pkg::TIME_W + 7) / 8) * 8,
  parameter int OUT_W    = ((KEY_BITS + 2 + cdt_pkg::TIME_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [cdt_pkg::STEP_W-1:0] cfg_wdata,
  input  logic [IN_W-1:0]            s_tdata,
  input  logic [1:0]                 s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_W-1:0]           m_tdata,
  output logic [1:0]                 m_tuser,
  output logic                       m_tlast,
  input  cdt_pkg::ctrl_t             ctl,
  output cdt_pkg::stat_t             st
);

  localparam int TW    = cdt_pkg::TIME_W;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [cdt_pkg::STEP_W-1:0] tick_step;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    wr;

  cdt_pkg::cmd_t       cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic                type_r;
  logic [TW-1:0]       dur_r;

  logic [KEY_BITS-1:0] mem_key  [DEPTH];
  logic                mem_type [DEPTH];
  logic [TW-1:0]       mem_time [DEPTH];

  logic [KEY_BITS-1:0] rd_key;
  logic                rd_type;
  logic [TW-1:0]       rd_time;

  logic                held_valid;
  logic [KEY_BITS-1:0] held_key;
  logic                held_type;

  logic [KEY_BITS-1:0] o_key;
  logic                o_type;
  logic [TW-1:0]       o_rem;
  logic                o_found;

  logic [TW-1:0]       step_ext;
  logic [TW-1:0]       t_dec;
  logic                full;
  logic                wen;
  logic [IDX_W-1:0]    waddr;
  logic [KEY_BITS-1:0] wkey;
  logic                wtype;
  logic [TW-1:0]       wtime;

  assign step_ext = TW'(tick_step);
  assign t_dec    = (rd_time > step_ext) ? (rd_time - step_ext) : '0;
  assign full     = (count == CNT_W'(DEPTH));

  assign st.cmd        = cmd_r;
  assign st.scan_done  = (idx == count);
  assign st.hit        = (rd_key == key_r) &&
                         ((cmd_r == cdt_pkg::CMD_QUERY_K) || (rd_type == type_r));
  assign st.expired    = (t_dec == '0);
  assign st.out_free   = !m_tvalid || m_tready;
  assign st.held_valid = held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= cdt_pkg::STEP_RESET;
    end else if (cfg_wen) begin
      tick_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= cdt_pkg::cmd_t'(s_tuser);
      key_r  <= s_tdata[KEY_BITS-1:0];
      type_r <= s_tdata[KEY_BITS];
      dur_r  <= s_tdata[KEY_BITS+TW:KEY_BITS+1];
    end
  end

  // scan index and compaction pointer
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      idx <= '0;
      wr  <= '0;
    end else begin
      if (ctl.step) begin
        idx <= idx + 1'b1;
      end
      if (ctl.keep) begin
        wr <= wr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push_write && !full) begin
      count <= count + 1'b1;
    end else if (ctl.commit) begin
      count <= wr;
    end
  end

  assign wen   = (ctl.push_write && !full) || ctl.keep;
  assign waddr = ctl.push_write ? count[IDX_W-1:0] : wr[IDX_W-1:0];
  assign wkey  = ctl.push_write ? key_r  : rd_key;
  assign wtype = ctl.push_write ? type_r : rd_type;
  assign wtime = ctl.push_write ? dur_r  : t_dec;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem_key[waddr]  <= wkey;
      mem_type[waddr] <= wtype;
      mem_time[waddr] <= wtime;
    end
    rd_key  <= mem_key[idx[IDX_W-1:0]];
    rd_type <= mem_type[idx[IDX_W-1:0]];
    rd_time <= mem_time[idx[IDX_W-1:0]];
  end

  // expiry held back until the next one shows whether it is the final word
  always_ff @(posedge clk) begin
    if (rst || ctl.load || ctl.commit) begin
      held_valid <= 1'b0;
    end else if (ctl.hold) begin
      held_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hold) begin
      held_key  <= rd_key;
      held_type <= rd_type;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      m_tlast <= ctl.out_last;
      unique case (ctl.out_sel)
        cdt_pkg::SEL_PUSH: begin
          m_tuser <= full ? cdt_pkg::EV_REJECTED : cdt_pkg::EV_STARTED;
          o_key   <= key_r;
          o_type  <= type_r;
          o_rem   <= dur_r;
          o_found <= 1'b0;
        end
        cdt_pkg::SEL_HIT: begin
          m_tuser <= cdt_pkg::EV_QUERY;
          o_key   <= key_r;
          o_type  <= (cmd_r == cdt_pkg::CMD_QUERY_K) ? rd_type : type_r;
          o_rem   <= rd_time;
          o_found <= 1'b1;
        end
        cdt_pkg::SEL_MISS: begin
          m_tuser <= cdt_pkg::EV_QUERY;
          o_key   <= key_r;
          o_type  <= (cmd_r == cdt_pkg::CMD_QUERY_K) ? 1'b0 : type_r;
          o_rem   <= '0;
          o_found <= 1'b0;
        end
        cdt_pkg::SEL_HELD: begin
          m_tuser <= cdt_pkg::EV_EXPIRED;
          o_key   <= held_key;
          o_type  <= held_type;
          o_rem   <= '0;
          o_found <= 1'b0;
        end
        default: begin
          m_tuser <= cdt_pkg::EV_QUERY;
          o_key   <= key_r;
          o_type  <= 1'b0;
          o_rem   <= '0;
          o_found <= 1'b0;
        end
      endcase
    end
  end

  assign m_tdata = OUT_W'({o_found, o_rem, o_type, o_key});

endmodule
